FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed: %m");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed: %m");
`endif

FILE: rtl/core/clle_pkg.sv
package clle_pkg;
	typedef enum logic [2:0] {
		OP_NEW    = 3'd0,
		OP_PUSH   = 3'd1,
		OP_FREE   = 3'd2,
		OP_LOCATE = 3'd3,
		OP_MERGE  = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [7:0]         index_a;
		logic [7:0]         index_b;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] result_index;
		logic [8:0] position;
		logic       status;
	} rsp_t;
endpackage

FILE: rtl/core/cursor_linked_list_engine.sv
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | clle_pkg::req_t
// rsp     | out | rsp_valid/rsp_ready | clle_pkg::rsp_t
// Each memory read has an issue phase and a data phase.
// After reset a link-init pass writes every node, one per cycle, with
// req_ready low. The response has its own register, so a held response
// stalls only the next completion, not the next request.
module cursor_linked_list_engine #(
	parameter int NODE_COUNT = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  clle_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output clle_pkg::rsp_t  rsp
);
	import clle_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = $clog2(NODE_COUNT);
	localparam logic [AW-1:0] LIMIT = AW'(NODE_COUNT - 1);

	typedef enum logic [15:0] {
		S_INIT  = 16'h0001, S_IDLE  = 16'h0002, S_HEAD  = 16'h0004,
		S_TAKE  = 16'h0008, S_ALLOC = 16'h0010, S_PUSHA = 16'h0020,
		S_FREE  = 16'h0040, S_LOCR  = 16'h0080, S_LOCV  = 16'h0100,
		S_MB    = 16'h0200, S_MBV   = 16'h0400, S_MA    = 16'h0800,
		S_MAV   = 16'h1000, S_MACT  = 16'h2000, S_DONE  = 16'h4000,
		S_WAIT  = 16'h8000
	} st_t;

	st_t st_q;
	logic [AW-1:0] cnt_q, a_q, b_q, n_q, ib_q, ia_q, steps_q, outer_q, inner_q;
	logic [AW-1:0] fhead_q, ahead_q, nxt_q, f0_q;
	logic [DATA_WIDTH-1:0] val_q, vb_q;
	logic [2:0] op_q;
	logic [1:0] ph_q;
	logic [8:0] k_q;
	rsp_t res_q, rsp_q;

	logic l_we, v_we;
	logic [AW-1:0] l_wa, l_wd, l_ra, l_rd, v_wa, v_ra;
	logic [DATA_WIDTH-1:0] v_wd, v_rd;

	clle_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_link (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
	clle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODE_COUNT)) u_val (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));

	// Write and read ports are driven from registered control; ph_q sequences
	// issue (0) and data (1) phases of most reads; some reads add wait phases.
	logic [AW-1:0] lw_a_q, lw_d_q, lr_a_q, vr_a_q, vw_a_q;
	logic lw_q, vw_q;
	logic [DATA_WIDTH-1:0] vw_d_q;
	assign l_we = lw_q;
	assign l_wa = lw_a_q;
	assign l_wd = lw_d_q;
	assign l_ra = lr_a_q;
	assign v_we = vw_q;
	assign v_wa = vw_a_q;
	assign v_wd = vw_d_q;
	assign v_ra = vr_a_q;

	assign req_ready = (st_q == S_IDLE);
	assign rsp = rsp_q;

	logic [DATA_WIDTH-1:0] in_val;
	assign in_val = DATA_WIDTH'($signed({{32{req.value[31]}}, req.value}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
			cnt_q <= '0;
			rsp_valid <= 1'b0;
			rsp_q <= '0;
			lw_q <= 1'b0;
			vw_q <= 1'b0;
			ph_q <= '0;
		end else begin
			lw_q <= 1'b0;
			vw_q <= 1'b0;
			if (rsp_valid && rsp_ready && st_q != S_DONE) begin
				rsp_valid <= 1'b0;
			end
			case (st_q)
			S_INIT: begin
				lw_q <= 1'b1;
				lw_a_q <= cnt_q;
				lw_d_q <= (cnt_q == LIMIT) ? '0 : cnt_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LIMIT) begin
					st_q <= S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid && req_ready) begin
					op_q <= req.operation;
					a_q <= AW'(req.index_a);
					b_q <= AW'(req.index_b);
					val_q <= in_val;
					res_q <= '0;
					ph_q <= '0;
					lr_a_q <= '0;
					case (req.operation)
					OP_NEW, OP_PUSH: st_q <= S_HEAD;
					OP_FREE: st_q <= (AW'(req.index_a) == '0) ? S_DONE : S_HEAD;
					OP_LOCATE: begin
						lr_a_q <= AW'(req.index_a);
						k_q <= 9'd1;
						steps_q <= '0;
						st_q <= S_LOCR;
					end
					OP_MERGE: begin
						lr_a_q <= AW'(req.index_b);
						outer_q <= '0;
						st_q <= S_MB;
					end
					default: st_q <= S_DONE;
					endcase
				end
			end
			S_HEAD: begin
				// read link[0]
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					fhead_q <= l_rd;
					ph_q <= '0;
					if (op_q == OP_FREE) begin
						lw_q <= 1'b1;
						lw_a_q <= a_q;
						lw_d_q <= l_rd;
						st_q <= S_FREE;
					end else if (l_rd == '0) begin
						res_q.status <= 1'b1;
						st_q <= S_DONE;
					end else begin
						lr_a_q <= l_rd;
						st_q <= S_TAKE;
					end
				end
			end
			S_FREE: begin
				lw_q <= 1'b1;
				lw_a_q <= '0;
				lw_d_q <= a_q;
				st_q <= S_DONE;
			end
			S_TAKE: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					n_q <= fhead_q;
					res_q.result_index <= 8'(fhead_q);
					lw_q <= 1'b1;
					lw_a_q <= '0;
					lw_d_q <= l_rd;
					lr_a_q <= a_q;
					st_q <= S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (op_q == OP_NEW) begin
					lw_q <= 1'b1;
					lw_a_q <= n_q;
					lw_d_q <= '0;
					st_q <= S_DONE;
				end else begin
					// read link[a] after the free-head write landed
					ph_q <= ph_q + 1'b1;
					lr_a_q <= a_q;
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						lw_q <= 1'b1;
						lw_a_q <= n_q;
						lw_d_q <= l_rd;
						vw_q <= 1'b1;
						vw_a_q <= n_q;
						vw_d_q <= val_q;
						st_q <= S_PUSHA;
					end
				end
			end
			S_PUSHA: begin
				lw_q <= 1'b1;
				lw_a_q <= a_q;
				lw_d_q <= n_q;
				st_q <= S_DONE;
			end
			S_LOCR: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					vr_a_q <= l_rd;
					if (l_rd == '0 || steps_q == LIMIT) begin
						res_q.position <= k_q;
						st_q <= S_DONE;
					end else begin
						lr_a_q <= l_rd;
						st_q <= S_LOCV;
					end
				end
			end
			S_LOCV: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					if (v_rd == val_q) begin
						res_q.position <= k_q;
						st_q <= S_DONE;
					end else begin
						k_q <= k_q + 1'b1;
						steps_q <= steps_q + 1'b1;
						st_q <= S_LOCR;
					end
				end
			end
			S_MB: begin
				// fetch first B node (link of B's head)
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					ib_q <= l_rd;
					vr_a_q <= l_rd;
					if (l_rd == '0 || outer_q == LIMIT) begin
						res_q.result_index <= 8'(a_q);
						st_q <= S_DONE;
					end else begin
						lr_a_q <= l_rd;
						st_q <= S_MBV;
					end
				end
			end
			S_MBV: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					vb_q <= v_rd;
					nxt_q <= l_rd;
					lr_a_q <= a_q;
					inner_q <= '0;
					ia_q <= '0;
					st_q <= S_MA;
				end
			end
			S_MA: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					if (ia_q == '0 && inner_q == '0) begin
						ahead_q <= l_rd;
					end
					ia_q <= l_rd;
					vr_a_q <= l_rd;
					if (l_rd == '0 || inner_q == LIMIT) begin
						st_q <= S_MACT;
						ph_q <= (l_rd == '0) ? 2'd0 : 2'd2;
					end else begin
						lr_a_q <= l_rd;
						st_q <= S_MAV;
					end
				end
			end
			S_MAV: begin
				ph_q <= ph_q + 1'b1;
				if (ph_q == 2'd1) begin
					ph_q <= '0;
					if (v_rd == vb_q) begin
						st_q <= S_MACT;
						ph_q <= 2'd1;
					end else begin
						inner_q <= inner_q + 1'b1;
						st_q <= S_MA;
					end
				end
			end
			S_MACT: begin
				// ph 1: found -> free ib; else (0, or 2 at limit: check value) move to A front
				if (ph_q == 2'd2) begin
					ph_q <= 2'd3;
				end else if (ph_q == 2'd3) begin
					ph_q <= (v_rd == vb_q) ? 2'd1 : 2'd0;
				end else begin
					if (ph_q == 2'd1) begin
						lw_q <= 1'b1;
						lw_a_q <= ib_q;
						lw_d_q <= f0_q;
						st_q <= S_WAIT;
						ph_q <= 2'd1;
					end else begin
						lw_q <= 1'b1;
						lw_a_q <= ib_q;
						lw_d_q <= ahead_q;
						st_q <= S_WAIT;
						ph_q <= 2'd0;
					end
				end
			end
			S_WAIT: begin
				lw_q <= 1'b1;
				lw_a_q <= (ph_q == 2'd1) ? '0 : a_q;
				lw_d_q <= ib_q;
				outer_q <= outer_q + 1'b1;
				// continue with the B successor saved before ib was relinked
				ib_q <= nxt_q;
				lr_a_q <= nxt_q;
				vr_a_q <= nxt_q;
				if (nxt_q == '0 || outer_q == LIMIT - 1'b1) begin
					res_q.result_index <= 8'(a_q);
					ph_q <= '0;
					st_q <= S_DONE;
				end else begin
					// extra issue cycle so the link read sees the write above
					ph_q <= 2'd3;
					st_q <= S_MBV;
				end
			end
			S_DONE: begin
				if (!rsp_valid || rsp_ready) begin
					rsp_valid <= 1'b1;
					rsp_q <= res_q;
					st_q <= S_IDLE;
				end
			end
			default: st_q <= S_IDLE;
			endcase
		end
	end

	// mirror of link[0], the free-list head, for merge frees
	always_ff @(posedge clk) begin
		if (lw_q && lw_a_q == '0) begin
			f0_q <= lw_d_q;
		end
	end

	`ASSERT_IMPLIES(a_ready_idle, clk, arst_n, req_ready, st_q == S_IDLE)
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`ASSERT_IMPLIES(a_no_wr_zero_val, clk, arst_n, v_we, v_wa != '0 || op_q == OP_PUSH)
endmodule

FILE: rtl/core/clle_ram.sv
module clle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
